### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands; expect clk and rst (sync, active high) in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every edge outside reset
`define CWEM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CWEM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cwem_pkg.sv
// ----------------------------------------------------------------------------
// cwem_pkg
// Shared types and constants of the cross-window edge marker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cwem_pkg;

  localparam int BRIGHT_W = 10;
  localparam int SLOTS    = 4;
  localparam int DIFF_W   = 13;
  localparam int MIN_SIZE = 5;

  localparam int MARGIN_W = 10;
  localparam int LWIDTH_W = 11;
  localparam int ROWS_W   = 10;
  localparam int POS_W    = 10;
  localparam int CFG_W    = 11;

  localparam logic [MARGIN_W-1:0] SIM_MARGIN_RST   = 10'd20;
  localparam logic [MARGIN_W-1:0] TREND_MARGIN_RST = 10'd50;
  localparam logic [LWIDTH_W-1:0] LINE_WIDTH_RST   = 11'd640;
  localparam logic [ROWS_W-1:0]   FRAME_ROWS_RST   = 10'd480;

  typedef enum logic [1:0] {
    CFG_SIM_MARGIN   = 2'd0,
    CFG_TREND_MARGIN = 2'd1,
    CFG_LINE_WIDTH   = 2'd2,
    CFG_FRAME_ROWS   = 2'd3
  } cfg_index_t;

  typedef logic [BRIGHT_W-1:0]        brightness_t;
  typedef brightness_t [SLOTS-1:0]    column_word_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;

  // differences of one arm, ready for the compare stage
  typedef struct packed {
    diff_t up;     // m - t
    diff_t dn;     // th - m
    diff_t g;      // up - dn
    diff_t a;      // (t - o) - up
    diff_t b;      // dn - (f - th)
  } arm_diff_t;

endpackage

`default_nettype wire

### rtl/core/cross_window_edge_marker_unit.sv
// ----------------------------------------------------------------------------
// cross_window_edge_marker_unit
// Marks edge pixels on a 5x5 cross around each interior center of an RGB
// raster stream; four brightness lines live in one column-wide memory.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on in_valid/in_ready (red, green, blue, frame_start) in raster
//   order. frame_start puts the beat at column 0, row 0. The pixel at (c, r)
//   judges the center (c, r-2); interior centers produce one result beat on
//   out_valid/out_ready, border pixels produce none.
//   A beat passes stage B, stage C and the result register. Throughput: one
//   pixel per cycle while results are taken, set by the line memory (one write
//   lane, two read ports per beat: current column and the column two ahead).
//   Configuration (cfg_write/cfg_index/cfg_data) is to be written by the user
//   only while idle; the unit does not check it. Reset returns registers to
//   defaults and position to zero; the line memory is not cleared, rows 0..3 of
//   a frame fill it before any result reads it. A stalled receiver holds the
//   result register; stages B and C take pixels until full, then in_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cross_window_edge_marker_unit #(
  parameter int LINE_MAX = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [cwem_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     red,
  input  logic [7:0]                     green,
  input  logic [7:0]                     blue,
  input  logic                           frame_start,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cwem_pkg::POS_W-1:0]     center_column,
  output logic [cwem_pkg::POS_W-1:0]     center_row,
  output logic                           edge_mark,
  output logic                           frame_last
);

  localparam int CW = $clog2(LINE_MAX);
  localparam int EW = CW + 1;
  localparam int WW = (EW > cwem_pkg::LWIDTH_W) ? EW : cwem_pkg::LWIDTH_W;
  localparam int RW = cwem_pkg::ROWS_W;

  // --------------------------------------------------------------------------
  // arm rule helpers
  function automatic cwem_pkg::diff_t to_diff(input cwem_pkg::brightness_t x);
    return cwem_pkg::diff_t'({3'b000, x});
  endfunction

  function automatic cwem_pkg::arm_diff_t arm_diffs(
    input cwem_pkg::brightness_t m, input cwem_pkg::brightness_t o,
    input cwem_pkg::brightness_t t, input cwem_pkg::brightness_t th,
    input cwem_pkg::brightness_t f);
    cwem_pkg::arm_diff_t r;
    r.up = to_diff(m) - to_diff(t);
    r.dn = to_diff(th) - to_diff(m);
    r.g  = r.up - r.dn;
    r.a  = (to_diff(t) - to_diff(o)) - r.up;
    r.b  = r.dn - (to_diff(f) - to_diff(th));
    return r;
  endfunction

  function automatic logic arm_pass(input cwem_pkg::arm_diff_t x,
                                    input cwem_pkg::diff_t s,
                                    input cwem_pkg::diff_t d);
    logic sim, lin, rise, fall;
    sim  = (x.up > -s) && (x.up < s) && (x.dn > -s) && (x.dn < s);
    lin  = (x.g > -s) && (x.g < s);
    rise = (x.g > d) && ((x.a > d) || (x.b > d));
    fall = (x.g < -d) && ((x.a < -d) || (x.b < -d));
    return !(sim || lin || rise || fall);
  endfunction

  // --------------------------------------------------------------------------
  // configuration
  logic [cwem_pkg::MARGIN_W-1:0] similarity_margin;
  logic [cwem_pkg::MARGIN_W-1:0] trend_margin;
  logic [cwem_pkg::LWIDTH_W-1:0] line_width;
  logic [RW-1:0]                 frame_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      similarity_margin <= cwem_pkg::SIM_MARGIN_RST;
      trend_margin      <= cwem_pkg::TREND_MARGIN_RST;
      line_width        <= cwem_pkg::LINE_WIDTH_RST;
      frame_rows        <= cwem_pkg::FRAME_ROWS_RST;
    end else if (cfg_write) begin
      case (cwem_pkg::cfg_index_t'(cfg_index))
        cwem_pkg::CFG_SIM_MARGIN:   similarity_margin <= cfg_data[cwem_pkg::MARGIN_W-1:0];
        cwem_pkg::CFG_TREND_MARGIN: trend_margin      <= cfg_data[cwem_pkg::MARGIN_W-1:0];
        cwem_pkg::CFG_LINE_WIDTH:   line_width        <= cfg_data[cwem_pkg::LWIDTH_W-1:0];
        cwem_pkg::CFG_FRAME_ROWS:   frame_rows        <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0] lw_ext;
  logic [WW-1:0] lw_clamp;
  logic [EW-1:0] w_eff;
  logic [RW-1:0] h_eff;

  always_comb begin
    lw_ext = WW'(line_width);
    if (lw_ext < WW'(cwem_pkg::MIN_SIZE)) begin
      lw_clamp = WW'(cwem_pkg::MIN_SIZE);
    end else if (lw_ext > WW'(LINE_MAX)) begin
      lw_clamp = WW'(LINE_MAX);
    end else begin
      lw_clamp = lw_ext;
    end
    w_eff = lw_clamp[EW-1:0];
    h_eff = (frame_rows < RW'(cwem_pkg::MIN_SIZE)) ? RW'(cwem_pkg::MIN_SIZE) : frame_rows;
  end

  // --------------------------------------------------------------------------
  // pipeline flow control: A (accept) -> B (memory data) -> C (diffs) -> out
  logic b_valid, c_valid, c_prod;
  logic en_out, en_c, en_b, accept;

  assign en_out   = !out_valid || out_ready;
  assign en_c     = !c_valid || !c_prod || en_out;
  assign en_b     = !b_valid || en_c;
  assign in_ready = en_b;
  assign accept   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // stage A: position and brightness
  logic [CW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic [CW-1:0] cur_c;
  logic [RW-1:0] cur_r;
  logic [EW-1:0] c_ext, c_plus1, c_plus2;
  logic [RW:0]   r_plus1;
  logic          interior, last_center;
  cwem_pkg::brightness_t bright;

  always_comb begin
    cur_c   = frame_start ? '0 : column_count;
    cur_r   = frame_start ? '0 : row_count;
    c_ext   = EW'(cur_c);
    c_plus1 = c_ext + EW'(1);
    c_plus2 = c_ext + EW'(2);
    r_plus1 = {1'b0, cur_r} + (RW+1)'(1);
    bright  = cwem_pkg::BRIGHT_W'(red) + cwem_pkg::BRIGHT_W'(green)
            + cwem_pkg::BRIGHT_W'(blue);

    interior    = (c_ext >= EW'(2)) && (c_plus2 < w_eff)
               && (cur_r >= RW'(4)) && (cur_r < h_eff);
    last_center = (c_ext == w_eff - EW'(3)) && (cur_r == h_eff - RW'(1));

    if (c_plus1 >= w_eff) begin
      column_count_next = '0;
      row_count_next    = (r_plus1 >= {1'b0, h_eff}) ? '0 : r_plus1[RW-1:0];
    end else begin
      column_count_next = c_plus1[CW-1:0];
      row_count_next    = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // --------------------------------------------------------------------------
  // line memory: one word per column, one lane per row slot (row mod 4).
  // Read-before-write: the current column still shows row r-4 in slot r.
  cwem_pkg::column_word_t line_mem [LINE_MAX];
  cwem_pkg::column_word_t rd_cur;    // column c
  cwem_pkg::column_word_t rd_ahead;  // column c + 2

  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[cur_c][cur_r[1:0]] <= bright;
      rd_cur   <= line_mem[cur_c];
      rd_ahead <= line_mem[c_plus2[CW-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // stage B
  logic                  b_prod, b_last;
  logic [cwem_pkg::POS_W-1:0] b_col, b_row;
  logic [1:0]            b_slot;
  cwem_pkg::brightness_t b_bright;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en_b) begin
      b_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_prod   <= interior;
      b_last   <= last_center;
      b_col    <= cwem_pkg::POS_W'(cur_c);
      b_row    <= cur_r - RW'(2);
      b_slot   <= cur_r[1:0];
      b_bright <= bright;
    end
  end

  // horizontal taps of the center row from the two previous beats
  cwem_pkg::brightness_t h_prev2, h_prev1, h_next1;
  cwem_pkg::brightness_t tap_m, tap_v0, tap_v1, tap_v3, tap_h4;
  logic [1:0]            sl_m;
  cwem_pkg::arm_diff_t   vert_diff, horz_diff;

  always_comb begin
    sl_m      = b_slot - 2'd2;
    tap_m     = rd_cur[sl_m];
    tap_v0    = rd_cur[b_slot];
    tap_v1    = rd_cur[b_slot + 2'd1];
    tap_v3    = rd_cur[b_slot - 2'd1];
    tap_h4    = rd_ahead[sl_m];
    vert_diff = arm_diffs(tap_m, tap_v0, tap_v1, tap_v3, b_bright);
    horz_diff = arm_diffs(tap_m, h_prev2, h_prev1, h_next1, tap_h4);
  end

  always_ff @(posedge clk) begin
    if (b_valid && en_c) begin
      h_prev2 <= h_prev1;
      h_prev1 <= tap_m;
      h_next1 <= tap_h4;
    end
  end

  // --------------------------------------------------------------------------
  // stage C
  logic                       c_last;
  logic [cwem_pkg::POS_W-1:0] c_col, c_row;
  cwem_pkg::arm_diff_t        c_vert, c_horz;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      c_prod  <= 1'b0;
    end else if (en_c) begin
      c_valid <= b_valid;
      c_prod  <= b_valid && b_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && b_valid) begin
      c_last <= b_last;
      c_col  <= b_col;
      c_row  <= b_row;
      c_vert <= vert_diff;
      c_horz <= horz_diff;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  cwem_pkg::diff_t s_ext, d_ext;

  assign s_ext = cwem_pkg::diff_t'({3'b000, similarity_margin});
  assign d_ext = cwem_pkg::diff_t'({3'b000, trend_margin});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= c_valid && c_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && c_valid && c_prod) begin
      center_column <= c_col;
      center_row    <= c_row;
      edge_mark     <= arm_pass(c_vert, s_ext, d_ext) || arm_pass(c_horz, s_ext, d_ext);
      frame_last    <= c_last;
    end
  end

  // --------------------------------------------------------------------------
  // checks
  `CWEM_ASSERT_NEXT(a_interior_reaches_b, accept && interior, b_valid && b_prod,
    "interior pixel lost between accept and stage B")
  `CWEM_ASSERT_NEXT(a_b_holds_on_stall, b_valid && !en_c, b_valid && $stable(b_col),
    "stage B changed while stalled")
  `CWEM_ASSERT(a_ready_has_room,
    !(in_ready && b_valid && c_valid && c_prod && out_valid && !out_ready),
    "input ready with all stages full")
  `CWEM_ASSERT(a_last_is_interior,
    !(out_valid && frame_last) || (center_column >= 10'd2 && center_row >= 10'd2),
    "frame_last on a border position")

endmodule

`default_nettype wire
